// File: rtl/core/pswrl_pkg.sv
// ----------------------------------------------------------------------------
// pswrl_pkg: shared types and constants of the per-source rate limiter
// field widths, register indexes, reset values, slot entry and sequencer states
// ----------------------------------------------------------------------------
package pswrl_pkg;

	localparam int ADDR_W     = 32;
	localparam int TIME_W     = 32;
	localparam int GCNT_W     = 16;
	localparam int SCNT_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_WINDOW_LENGTH    = 2'd0;
	localparam cfg_idx_t REG_GLOBAL_LIMIT     = 2'd1;
	localparam cfg_idx_t REG_PER_SOURCE_LIMIT = 2'd2;

	localparam logic [TIME_W-1:0] WINDOW_LENGTH_RESET    = 32'd1000;
	localparam logic [GCNT_W-1:0] GLOBAL_LIMIT_RESET     = 16'd64;
	localparam logic [SCNT_W-1:0] PER_SOURCE_LIMIT_RESET = 8'd8;

	typedef struct packed {
		logic [ADDR_W-1:0] source;
		logic [TIME_W-1:0] window_start;
		logic [SCNT_W-1:0] count;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GLOB,
		ST_SCAN,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

// File: rtl/core/pswrl_ram.sv
// ----------------------------------------------------------------------------
// pswrl_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pswrl_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/pswrl_expiry_unit.sv
// ----------------------------------------------------------------------------
// pswrl_expiry_unit: shared window expiry compare
// wrapping 32-bit difference of now and a window start against the window length
// ----------------------------------------------------------------------------
module pswrl_expiry_unit (
	input  logic [pswrl_pkg::TIME_W-1:0] now_ms,
	input  logic [pswrl_pkg::TIME_W-1:0] start_ms,
	input  logic [pswrl_pkg::TIME_W-1:0] window_length_ms,
	output logic                         expired
);

	logic [pswrl_pkg::TIME_W-1:0] elapsed;

	assign elapsed = now_ms - start_ms;
	assign expired = (elapsed >= window_length_ms);

endmodule

// File: rtl/core/per_source_window_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// per_source_window_rate_limiter_core: per-source fixed-window request limiter
// a request passes ST_GLOB, ST_SCAN, ST_CHECK and ST_DONE in turn, a hit ending the scan early;
// a zero source or global deny goes from ST_GLOB straight to ST_DONE
// one request at a time; the slot scan reads one ram entry per cycle
// reset clears counts, windows, cursor and slot valid bits; ram contents are kept
// ----------------------------------------------------------------------------
module per_source_window_rate_limiter_core #(
	parameter int SOURCE_SLOTS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [63:0]                         s_tdata,  // [31:0] source_address, [63:32] now_ms
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,  // [0] allowed, [7:1] zero
	input  logic                                cfg_we,
	input  logic [pswrl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pswrl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
	localparam int CNT_W = $clog2(SOURCE_SLOTS + 1);

	pswrl_pkg::state_t state_q, state_d;

	logic [pswrl_pkg::TIME_W-1:0] win_q;
	logic [pswrl_pkg::GCNT_W-1:0] glim_q;
	logic [pswrl_pkg::SCNT_W-1:0] plim_q;

	logic                         started_q;
	logic [pswrl_pkg::TIME_W-1:0] gws_q;
	logic [pswrl_pkg::GCNT_W-1:0] gcnt_q;
	logic [IDX_W-1:0]             cursor_q;
	logic [SOURCE_SLOTS-1:0]      slot_valid_q;

	logic [pswrl_pkg::ADDR_W-1:0] src_q;
	logic [pswrl_pkg::TIME_W-1:0] now_q;

	logic [CNT_W-1:0]             rd_cnt_q;
	logic                         pend_s1;
	logic [IDX_W-1:0]             pend_idx_s1;
	logic                         have_free_q;
	logic [IDX_W-1:0]             free_idx_q;
	logic [IDX_W-1:0]             slot_idx_q;
	pswrl_pkg::slot_t             entry_q;
	logic                         res_q;
	logic                         m_tvalid_q;
	logic                         m_allow_q;

	logic                         issue;
	logic [IDX_W-1:0]             rd_idx;
	logic                         pend_valid;
	logic                         hit;
	logic                         free_now;
	logic [IDX_W-1:0]             free_idx_now;
	logic                         miss_done;
	logic [IDX_W-1:0]             cursor_next;
	logic [pswrl_pkg::TIME_W-1:0] exp_start;
	logic                         expired;
	logic                         g_restart;
	logic [pswrl_pkg::GCNT_W-1:0] gcnt_eff;
	logic                         g_deny;
	logic                         s_exp;
	logic [pswrl_pkg::TIME_W-1:0] ws_eff;
	logic [pswrl_pkg::SCNT_W-1:0] cnt_eff;
	logic                         allow_c;
	logic                         out_load;
	logic                         ram_we;
	pswrl_pkg::slot_t             ram_wdata;
	pswrl_pkg::slot_t             ram_rdata;

	pswrl_ram #(
		.WIDTH ($bits(pswrl_pkg::slot_t)),
		.DEPTH (SOURCE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_idx_q),
		.wdata (ram_wdata),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	pswrl_expiry_unit u_expiry (
		.now_ms           (now_q),
		.start_ms         (exp_start),
		.window_length_ms (win_q),
		.expired          (expired)
	);

	// slot scan
	assign issue        = (rd_cnt_q != CNT_W'(SOURCE_SLOTS));
	assign rd_idx       = rd_cnt_q[IDX_W-1:0];
	assign pend_valid   = slot_valid_q[pend_idx_s1];
	assign hit          = pend_s1 && pend_valid && (ram_rdata.source == src_q);
	assign free_now     = have_free_q || (pend_s1 && !pend_valid);
	assign free_idx_now = have_free_q ? free_idx_q : pend_idx_s1;
	assign miss_done    = !issue && !hit;
	assign cursor_next  = (cursor_q == IDX_W'(SOURCE_SLOTS - 1)) ? '0 : cursor_q + 1'b1;

	// shared expiry compare: global window, then slot window
	assign exp_start = (state_q == pswrl_pkg::ST_GLOB) ? gws_q : entry_q.window_start;

	assign g_restart = !started_q || expired;
	assign gcnt_eff  = g_restart ? '0 : gcnt_q;
	assign g_deny    = (src_q == '0) || (gcnt_eff >= glim_q);

	assign s_exp   = expired;
	assign ws_eff  = s_exp ? now_q : entry_q.window_start;
	assign cnt_eff = s_exp ? '0 : entry_q.count;
	assign allow_c = (cnt_eff < plim_q);

	always_comb begin
		ram_wdata.source       = src_q;
		ram_wdata.window_start = ws_eff;
		ram_wdata.count        = allow_c ? cnt_eff + 8'd1 : cnt_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pswrl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		ram_we   = 1'b0;
		unique case (state_q)
			pswrl_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pswrl_pkg::ST_GLOB;
				end
			end
			pswrl_pkg::ST_GLOB: begin
				state_d = g_deny ? pswrl_pkg::ST_DONE : pswrl_pkg::ST_SCAN;
			end
			pswrl_pkg::ST_SCAN: begin
				if (hit || miss_done) begin
					state_d = pswrl_pkg::ST_CHECK;
				end
			end
			pswrl_pkg::ST_CHECK: begin
				ram_we  = 1'b1;
				state_d = pswrl_pkg::ST_DONE;
			end
			pswrl_pkg::ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
				if (out_load) begin
					state_d = pswrl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pswrl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q        <= pswrl_pkg::WINDOW_LENGTH_RESET;
			glim_q       <= pswrl_pkg::GLOBAL_LIMIT_RESET;
			plim_q       <= pswrl_pkg::PER_SOURCE_LIMIT_RESET;
			started_q    <= 1'b0;
			gws_q        <= '0;
			gcnt_q       <= '0;
			cursor_q     <= '0;
			slot_valid_q <= '0;
			rd_cnt_q     <= '0;
			pend_s1      <= 1'b0;
			have_free_q  <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pswrl_pkg::REG_WINDOW_LENGTH:    win_q  <= cfg_data;
					pswrl_pkg::REG_GLOBAL_LIMIT:     glim_q <= cfg_data[pswrl_pkg::GCNT_W-1:0];
					pswrl_pkg::REG_PER_SOURCE_LIMIT: plim_q <= cfg_data[pswrl_pkg::SCNT_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				pswrl_pkg::ST_GLOB: begin
					if ((src_q != '0) && g_restart) begin
						started_q <= 1'b1;
						gws_q     <= now_q;
						gcnt_q    <= '0;
					end
					rd_cnt_q    <= '0;
					pend_s1     <= 1'b0;
					have_free_q <= 1'b0;
				end
				pswrl_pkg::ST_SCAN: begin
					pend_s1 <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (!have_free_q && pend_s1 && !pend_valid) begin
						have_free_q <= 1'b1;
					end
					if (miss_done && !free_now) begin
						cursor_q <= cursor_next;
					end
				end
				pswrl_pkg::ST_CHECK: begin
					slot_valid_q[slot_idx_q] <= 1'b1;
					if (allow_c) begin
						gcnt_q <= gcnt_q + 16'd1;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			src_q <= s_tdata[31:0];
			now_q <= s_tdata[63:32];
		end
		if ((state_q == pswrl_pkg::ST_SCAN) && issue) begin
			pend_idx_s1 <= rd_idx;
		end
		if ((state_q == pswrl_pkg::ST_SCAN) && !have_free_q && pend_s1 && !pend_valid) begin
			free_idx_q <= pend_idx_s1;
		end
		if ((state_q == pswrl_pkg::ST_SCAN) && hit) begin
			slot_idx_q <= pend_idx_s1;
			entry_q    <= ram_rdata;
		end else if ((state_q == pswrl_pkg::ST_SCAN) && miss_done) begin
			slot_idx_q           <= free_now ? free_idx_now : cursor_q;
			entry_q.source       <= src_q;
			entry_q.window_start <= now_q;
			entry_q.count        <= '0;
		end
		if (state_q == pswrl_pkg::ST_GLOB) begin
			res_q <= 1'b0;
		end else if (state_q == pswrl_pkg::ST_CHECK) begin
			res_q <= allow_c;
		end
		if (out_load) begin
			m_allow_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_allow_q};

	a_allow_nonzero_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_q) |-> (src_q != '0))
		else $error("allowed result for a zero source");

	a_global_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == pswrl_pkg::ST_CHECK) && allow_c) |=> (gcnt_q == $past(gcnt_q) + 16'd1))
		else $error("global count not incremented on admit");

	a_cursor_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q != $past(cursor_q)) |-> (&$past(slot_valid_q)))
		else $error("replace cursor moved while a free slot existed");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pswrl_pkg::ST_SCAN) |-> (rd_cnt_q <= CNT_W'(SOURCE_SLOTS)))
		else $error("slot scan ran past the last slot");

endmodule
